@@ hw/rtl/cbc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cbc_pkg;

  // Number of cartridge banks fitted; bank requests above it are dropped
  localparam int unsigned CART_BANKS = 32;

  localparam int unsigned OFFSET_W  = 14;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BANK_SEL_W = 5;
  localparam int unsigned SPECIAL_W = 6;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Window offsets that act
  localparam logic [OFFSET_W-1:0] OFS_CONFIRM = 14'd0;
  localparam logic [OFFSET_W-1:0] OFS_COMMAND = 14'd1;
  localparam logic [OFFSET_W-1:0] OFS_DATA1   = 14'd2;
  localparam logic [OFFSET_W-1:0] OFS_DATA2   = 14'd3;

  // Command codes
  localparam logic [BYTE_W-1:0] CMD_NONE      = 8'd0;
  localparam logic [BYTE_W-1:0] CMD_BANK_LAST = 8'd32;
  localparam logic [BYTE_W-1:0] CMD_BIOS_A    = 8'd33;
  localparam logic [BYTE_W-1:0] CMD_BIOS_B    = 8'd34;
  localparam logic [BYTE_W-1:0] CMD_CPU_RESET = 8'd36;
  localparam logic [BYTE_W-1:0] CMD_SPECIAL   = 8'd40;

  // data2 bits of the special command
  localparam logic [BYTE_W-1:0] D2_DISABLE = 8'h08;
  localparam logic [BYTE_W-1:0] D2_LOCK    = 8'h04;
  localparam logic [BYTE_W-1:0] D2_NMI     = 8'h02;
  localparam logic [BYTE_W-1:0] D2_RESET   = 8'h01;

  // Configuration register indexes
  localparam logic [0:0] REG_CART_MODE = 1'b0;
  localparam logic [0:0] REG_MACHINE   = 1'b1;

  typedef struct packed {
    logic                  hit;
    logic [SPECIAL_W-1:0]  bank;
  } map_req_t;

  typedef struct packed {
    logic                  map_update;
    logic                  map_source;
    logic [BANK_SEL_W-1:0] bank_select;
    logic                  bios_half;
    logic [SPECIAL_W-1:0]  special_bank;
    logic                  nmi_request;
    logic                  cpu_reset;
    logic                  device_disabled;
    logic                  device_locked;
  } result_t;

  // Mapping request: 1..32 a cartridge bank (if fitted), 33/34 the BIOS
  function automatic map_req_t map_request(input logic [BYTE_W-1:0] num);
    map_req_t r;
    r.hit  = 1'b0;
    r.bank = '0;
    if (num != CMD_NONE && num <= CMD_BANK_LAST) begin
      if (32'(num) <= CART_BANKS) begin
        r.hit  = 1'b1;
        r.bank = num[SPECIAL_W-1:0];
      end
    end else if (num == CMD_BIOS_A || num == CMD_BIOS_B) begin
      r.hit  = 1'b1;
      r.bank = '0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/cbc_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface cbc_in_if;
  logic        valid;
  logic        ready;
  logic [13:0] write_offset;
  logic [7:0]  write_value;
  logic        rom_page_bit;

  modport source (output valid, output write_offset, output write_value,
                  output rom_page_bit, input ready);
  modport sink (input valid, input write_offset, input write_value,
                input rom_page_bit, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/cbc_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface cbc_out_if;
  logic       valid;
  logic       ready;
  logic       map_update;
  logic       map_source;
  logic [4:0] bank_select;
  logic       bios_half;
  logic [5:0] special_bank;
  logic       nmi_request;
  logic       cpu_reset;
  logic       device_disabled;
  logic       device_locked;

  modport source (output valid, output map_update, output map_source,
                  output bank_select, output bios_half, output special_bank,
                  output nmi_request, output cpu_reset, output device_disabled,
                  output device_locked, input ready);
  modport sink (input valid, input map_update, input map_source,
                input bank_select, input bios_half, input special_bank,
                input nmi_request, input cpu_reset, input device_disabled,
                input device_locked, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/cartridge_bank_command_controller_top.sv @@
// Cartridge bank command controller.
// in_ch carries one CPU write into the low 16K ROM window per transaction
// (offset, data byte, current 128K ROM-select bit). out_ch returns exactly
// one result per write: the mapping now in force, whether this write changed
// it, NMI / CPU-reset pulses, and the disabled / locked flags.
// The cfg_ APB port holds two registers: cart mode enable at 0x0 and the
// 128K machine select at 0x4; writes are single setup+access, pready is tied
// high, reads return the stored bit.
// The result of a write is registered and shows on out_ch from the edge that
// accepts it. One write per cycle unless out_ch stalls; all latch, counter and
// mapping updates settle in the accept cycle into the result register.
// in_ch.ready is high whenever the result register is empty or being drained
// in the same cycle, so a stalled receiver holds the result and stops intake
// after one item; nothing is dropped.
// Reset (rst_n low, synchronous) clears every latch, the pulse counter, the
// disabled and locked flags, both config bits, and maps the BIOS.
// The disabled flag is left only through reset.
`timescale 1ns / 1ps
`default_nettype none
module cartridge_bank_command_controller_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  cbc_in_if.sink                              in_ch,
  cbc_out_if.source                           out_ch,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [cbc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [cbc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [cbc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                cfg_pready
);

  logic                             cart_mode_r;
  logic                             machine_128k_r;

  logic [cbc_pkg::BYTE_W-1:0]       command_r, command_nxt;
  logic [cbc_pkg::BYTE_W-1:0]       data1_r, data1_nxt;
  logic [cbc_pkg::BYTE_W-1:0]       data2_r, data2_nxt;
  logic [cbc_pkg::BYTE_W-1:0]       counted_r, counted_nxt;
  logic [cbc_pkg::BYTE_W-1:0]       pulse_cnt_r, pulse_cnt_nxt;
  logic                             counting_r, counting_nxt;
  logic                             disabled_r, disabled_nxt;
  logic                             locked_r, locked_nxt;
  logic [cbc_pkg::SPECIAL_W-1:0]    bank_r, bank_nxt;

  cbc_pkg::result_t                 res_r, res_nxt;
  logic                             out_valid_r;

  logic                             accept;
  logic                             cfg_wr;
  logic                             upd, nmi, rst;
  cbc_pkg::map_req_t                req;
  logic [cbc_pkg::BYTE_W-1:0]       cc1, pc1;
  logic                             bios;

  function automatic logic [cbc_pkg::BANK_SEL_W-1:0] BANK_SEL_FROM(
    input logic [cbc_pkg::SPECIAL_W-1:0] b);
    logic [cbc_pkg::SPECIAL_W-1:0] m;
    m = b - 6'd1;
    return m[cbc_pkg::BANK_SEL_W-1:0];
  endfunction

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cart_mode_r    <= 1'b0;
      machine_128k_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        cbc_pkg::REG_CART_MODE: cart_mode_r    <= cfg_pwdata[0];
        cbc_pkg::REG_MACHINE:   machine_128k_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[2])
      cbc_pkg::REG_CART_MODE: cfg_prdata[0] = cart_mode_r;
      cbc_pkg::REG_MACHINE:   cfg_prdata[0] = machine_128k_r;
      default:                cfg_prdata    = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // ---------------- command decode ----------------
  always_comb begin
    command_nxt   = command_r;
    data1_nxt     = data1_r;
    data2_nxt     = data2_r;
    counted_nxt   = counted_r;
    pulse_cnt_nxt = pulse_cnt_r;
    counting_nxt  = counting_r;
    disabled_nxt  = disabled_r;
    locked_nxt    = locked_r;
    bank_nxt      = bank_r;
    upd           = 1'b0;
    nmi           = 1'b0;
    rst           = 1'b0;
    req           = '0;
    // a new count run starts from the written value
    cc1           = counting_r ? counted_r : in_ch.write_value;
    pc1           = (counting_r ? pulse_cnt_r : '0) + 8'd1;

    if (cart_mode_r && !disabled_r) begin
      case (in_ch.write_offset)
        cbc_pkg::OFS_CONFIRM: begin
          if (command_r == cbc_pkg::CMD_SPECIAL) begin
            if (data1_r != cbc_pkg::CMD_NONE && data1_r <= cbc_pkg::CMD_BIOS_A)
              req = cbc_pkg::map_request(data1_r);
            if ((data2_r & cbc_pkg::D2_DISABLE) != '0) disabled_nxt = 1'b1;
            if ((data2_r & cbc_pkg::D2_LOCK) != '0)    locked_nxt   = 1'b1;
            nmi = (data2_r & cbc_pkg::D2_NMI) != '0;
            rst = (data2_r & cbc_pkg::D2_RESET) != '0;
          end else if (command_r != cbc_pkg::CMD_NONE
                       && command_r <= cbc_pkg::CMD_BIOS_B) begin
            req = cbc_pkg::map_request(command_r);
          end else if (command_r == cbc_pkg::CMD_CPU_RESET) begin
            rst = 1'b1;
          end
          counting_nxt = 1'b0;
        end
        cbc_pkg::OFS_COMMAND: begin
          command_nxt   = in_ch.write_value;
          counted_nxt   = cc1;
          pulse_cnt_nxt = pc1;
          counting_nxt  = 1'b1;
          if (in_ch.write_value < cbc_pkg::CMD_SPECIAL && pc1 == cc1) begin
            if (cc1 != cbc_pkg::CMD_NONE && cc1 <= cbc_pkg::CMD_BIOS_B)
              req = cbc_pkg::map_request(cc1);
            else if (cc1 == cbc_pkg::CMD_CPU_RESET)
              rst = 1'b1;
            counting_nxt = 1'b0;
          end else if (cc1 != in_ch.write_value) begin
            // command changed mid-count: restart on the new one
            pulse_cnt_nxt = 8'd1;
            counted_nxt   = in_ch.write_value;
          end
        end
        cbc_pkg::OFS_DATA1: data1_nxt = in_ch.write_value;
        cbc_pkg::OFS_DATA2: data2_nxt = in_ch.write_value;
        default: ;
      endcase
    end

    if (req.hit) begin
      upd      = 1'b1;
      bank_nxt = req.bank;
    end

    bios                     = (bank_nxt == '0);
    res_nxt.map_update       = upd;
    res_nxt.map_source       = bios;
    res_nxt.bank_select      = bios ? '0 : BANK_SEL_FROM(bank_nxt);
    res_nxt.bios_half        = bios && machine_128k_r && in_ch.rom_page_bit;
    res_nxt.special_bank     = bank_nxt;
    res_nxt.nmi_request      = nmi;
    res_nxt.cpu_reset        = rst;
    res_nxt.device_disabled  = disabled_nxt;
    res_nxt.device_locked    = locked_nxt;
  end

  // ---------------- state and result registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_r   <= '0;
      data1_r     <= '0;
      data2_r     <= '0;
      counted_r   <= '0;
      pulse_cnt_r <= '0;
      counting_r  <= 1'b0;
      disabled_r  <= 1'b0;
      locked_r    <= 1'b0;
      bank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        command_r   <= command_nxt;
        data1_r     <= data1_nxt;
        data2_r     <= data2_nxt;
        counted_r   <= counted_nxt;
        pulse_cnt_r <= pulse_cnt_nxt;
        counting_r  <= counting_nxt;
        disabled_r  <= disabled_nxt;
        locked_r    <= locked_nxt;
        bank_r      <= bank_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_r <= res_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.map_update      = res_r.map_update;
  assign out_ch.map_source      = res_r.map_source;
  assign out_ch.bank_select     = res_r.bank_select;
  assign out_ch.bios_half       = res_r.bios_half;
  assign out_ch.special_bank    = res_r.special_bank;
  assign out_ch.nmi_request     = res_r.nmi_request;
  assign out_ch.cpu_reset       = res_r.cpu_reset;
  assign out_ch.device_disabled = res_r.device_disabled;
  assign out_ch.device_locked   = res_r.device_locked;

endmodule
`default_nettype wire

@@ hw/rtl/cbc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cbc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       map_update,
  input wire logic       map_source,
  input wire logic [4:0] bank_select,
  input wire logic       bios_half,
  input wire logic [5:0] special_bank,
  input wire logic       nmi_request,
  input wire logic       cpu_reset,
  input wire logic       device_disabled,
  input wire logic       device_locked
);

  logic seen_disabled_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      seen_disabled_r <= 1'b0;
    else if (out_valid && out_ready && device_disabled)
      seen_disabled_r <= 1'b1;
  end

  // a held result must not change under the receiver
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(map_update)
      && $stable(special_bank) && $stable(nmi_request) && $stable(cpu_reset)
      && $stable(device_disabled) && $stable(device_locked) && $stable(bios_half))
    else $error("result changed while stalled");

  // an empty result register must always take a new transaction
  a_intake: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("intake blocked with empty result register");

  // mapping fields agree with each other
  a_map_view: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (map_source == (special_bank == 6'd0))
      && (!bios_half || map_source)
      && (map_source ? bank_select == 5'd0
                     : {1'b0, bank_select} == special_bank - 6'd1))
    else $error("inconsistent mapping fields");

  // once switched off the device stays off and acts on nothing
  a_disabled_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_disabled_r |-> device_disabled && !map_update
      && !nmi_request && !cpu_reset)
    else $error("disabled device acted or re-enabled");

endmodule

bind cartridge_bank_command_controller_top cbc_checker u_cbc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .map_update      (out_ch.map_update),
  .map_source      (out_ch.map_source),
  .bank_select     (out_ch.bank_select),
  .bios_half       (out_ch.bios_half),
  .special_bank    (out_ch.special_bank),
  .nmi_request     (out_ch.nmi_request),
  .cpu_reset       (out_ch.cpu_reset),
  .device_disabled (out_ch.device_disabled),
  .device_locked   (out_ch.device_locked)
);
`default_nettype wire
